FILE: hdl/pst_pkg.sv
// Package for the parabolic stop-and-reverse tracker.
// Holds the word types, the bar phase tags, register indexes and reset values.
// No dependencies.
package pst_pkg;

  localparam int PRICE_W = 32;
  localparam int ACCEL_W = 16;
  localparam int FRAC_W  = 16;

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [ACCEL_W-1:0] accel_t;

  // Register indexes of the configuration port
  typedef enum logic [0:0] {
    REG_AF_STEP = 1'b0,
    REG_AF_MAX  = 1'b1
  } reg_index_t;

  localparam accel_t AF_STEP_RESET = 16'd1311;
  localparam accel_t AF_MAX_RESET  = 16'd13107;

  // Position of a bar in the stream, set by the front
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_RUN    = 2'd2
  } bar_phase_t;

  typedef struct packed {
    price_t high_price;
    price_t low_price;
  } bar_t;

  typedef struct packed {
    price_t sar_level;
    price_t sar_next;
    logic   trend_long;
    logic   reversal;
  } result_t;

  // Bar word tagged with its phase, as queued between front and back
  typedef struct packed {
    bar_phase_t phase;
    bar_t       bar;
  } tagged_bar_t;

  typedef struct packed {
    accel_t af_step;
    accel_t af_max;
  } cfg_t;

endpackage

FILE: hdl/pst_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Generic in width and depth; no package dependency.
module pst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/pst_front.sv
// Front of the tracker: accepts bar words and tags each with its stream phase.
// Depends on pst_pkg.
module pst_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  pst_pkg::bar_t        bar,
  output logic                 q_push,
  input  logic                 q_full,
  output pst_pkg::tagged_bar_t q_word
);
  import pst_pkg::*;

  bar_phase_t phase;
  bar_phase_t phase_next;
  logic       accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  // Tag the word with the phase of this bar
  always_comb begin
    q_word.phase = phase;
    q_word.bar   = bar;
  end

  // Step the phase: first bar, second bar, then steady running
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_FIRST:  phase_next = PH_SECOND;
        PH_SECOND: phase_next = PH_RUN;
        PH_RUN:    phase_next = PH_RUN;
        default:   phase_next = PH_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

FILE: hdl/pst_back.sv
// Back of the tracker: runs the stop-and-reverse update for one bar per cycle
// if a bar waits and results have room. Holds trend state; depends on pst_pkg.
module pst_back (
  input  logic                 clk,
  input  logic                 rst,
  input  pst_pkg::cfg_t        cfg,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  pst_pkg::tagged_bar_t q_word,
  output logic                 r_push,
  input  logic                 r_full,
  output pst_pkg::result_t     r_word
);
  import pst_pkg::*;

  price_t pending_sar;
  price_t extreme_point;
  accel_t accel;
  logic   long_flag;
  price_t max_high_since_rev;
  price_t min_low_since_rev;
  price_t prior_high;
  price_t prior_low;

  price_t pending_sar_next;
  price_t extreme_point_next;
  accel_t accel_next;
  logic   long_flag_next;
  price_t max_high_next;
  price_t min_low_next;

  logic   take;
  price_t h;
  price_t l;
  price_t sar;
  logic   rev;
  price_t run_high;
  price_t run_low;
  logic   [ACCEL_W:0] accel_sum;

  logic   neg;
  price_t mag;
  logic   [PRICE_W+ACCEL_W-1:0] prod;
  logic   [PRICE_W+ACCEL_W-1:0] prod_adj;
  price_t delta;
  logic   [PRICE_W:0] up_sum;
  price_t proj;
  price_t next;

  assign take  = !q_empty && !r_full;
  assign q_pop = take;
  assign r_push = take;
  assign h = q_word.bar.high_price;
  assign l = q_word.bar.low_price;
  assign run_high = (h > max_high_since_rev) ? h : max_high_since_rev;
  assign run_low  = (l < min_low_since_rev) ? l : min_low_since_rev;

  // Decide reversal, extreme point and acceleration for this bar
  always_comb begin
    sar                = pending_sar;
    rev                = 1'b0;
    extreme_point_next = extreme_point;
    accel_next         = accel;
    long_flag_next     = long_flag;
    max_high_next      = run_high;
    min_low_next       = run_low;
    accel_sum          = {1'b0, accel} + {1'b0, cfg.af_step};
    unique case (q_word.phase)
      PH_FIRST: begin
        max_high_next  = h;
        min_low_next   = l;
        long_flag_next = 1'b0;
      end
      PH_SECOND: begin
        sar                = run_high;
        extreme_point_next = l;
        accel_next         = cfg.af_step;
        long_flag_next     = 1'b0;
      end
      default: begin
        if (long_flag && (pending_sar > l)) begin
          rev                = 1'b1;
          long_flag_next     = 1'b0;
          sar                = run_high;
          extreme_point_next = l;
          accel_next         = cfg.af_step;
        end else if (!long_flag && (pending_sar < h)) begin
          rev                = 1'b1;
          long_flag_next     = 1'b1;
          sar                = run_low;
          extreme_point_next = h;
          accel_next         = cfg.af_step;
        end
        if (rev) begin
          max_high_next = h;
          min_low_next  = l;
        end else if (long_flag ? (h > extreme_point) : (l < extreme_point)) begin
          extreme_point_next = long_flag ? h : l;
          accel_next = (accel_sum > {1'b0, cfg.af_max}) ? cfg.af_max
                                                        : accel_sum[ACCEL_W-1:0];
        end
      end
    endcase
  end

  // Project toward the extreme point, rounding the step toward minus infinity
  always_comb begin
    neg      = (extreme_point_next < sar);
    mag      = neg ? (sar - extreme_point_next) : (extreme_point_next - sar);
    prod     = {{ACCEL_W{1'b0}}, mag} * {{PRICE_W{1'b0}}, accel_next};
    prod_adj = neg ? (prod + {{PRICE_W{1'b0}}, {FRAC_W{1'b1}}}) : prod;
    delta    = prod_adj[PRICE_W+ACCEL_W-1:FRAC_W];
    up_sum   = {1'b0, sar} + {1'b0, delta};
    if (neg) begin
      proj = (delta > sar) ? '0 : (sar - delta);
    end else begin
      proj = up_sum[PRICE_W] ? '1 : up_sum[PRICE_W-1:0];
    end
  end

  // Clamp against this bar and the previous bar
  always_comb begin
    next = proj;
    if (long_flag_next) begin
      if ((proj > l) || (proj > prior_low)) begin
        next = (l < prior_low) ? l : prior_low;
      end
    end else begin
      if ((proj < h) || (proj < prior_high)) begin
        next = (h > prior_high) ? h : prior_high;
      end
    end
    pending_sar_next = (q_word.phase == PH_FIRST) ? pending_sar : next;
  end

  // Form the result word
  always_comb begin
    if (q_word.phase == PH_FIRST) begin
      r_word.sar_level  = h;
      r_word.sar_next   = h;
      r_word.trend_long = 1'b0;
      r_word.reversal   = 1'b0;
    end else begin
      r_word.sar_level  = sar;
      r_word.sar_next   = next;
      r_word.trend_long = long_flag_next;
      r_word.reversal   = rev;
    end
  end

  // Commit trend state when a bar is carried out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_sar        <= '0;
      extreme_point      <= '0;
      accel              <= AF_STEP_RESET;
      long_flag          <= 1'b0;
      max_high_since_rev <= '0;
      min_low_since_rev  <= '1;
      prior_high         <= '0;
      prior_low          <= '0;
    end else if (take) begin
      pending_sar        <= pending_sar_next;
      extreme_point      <= extreme_point_next;
      accel              <= accel_next;
      long_flag          <= long_flag_next;
      max_high_since_rev <= max_high_next;
      min_low_since_rev  <= min_low_next;
      prior_high         <= h;
      prior_low          <= l;
    end
  end

endmodule

FILE: hdl/parabolic_sar_tracker.sv
// Parabolic stop-and-reverse tracker over a stream of price bars.
// Feeds bar words to the channel;
// depends on pst_pkg, pst_fifo, pst_front and pst_back.
// Channels: bar words (high and low price) enter by push while full is low.
// Result words (stop level, projected level, trend, reversal flag) wait in
// a result queue; the oldest sits on result while empty is low and leaves
// on pop. One result word comes out per bar word, in order.
// Configuration: cfg_wr writes cfg_data into the register at cfg_index
// (0 acceleration step, 1 acceleration ceiling) at once; write while idle.
// Path: the front tags each bar into the bar queue; the back turns the queue
// head into a result word for the result queue; both queues are registered.
// Throughput: one bar per cycle while the result queue has room; the back
// takes a waiting bar per cycle, its acceleration multiply combinational.
// Stall: when pop is held low the result queue fills, the back holds, the
// bar queue fills and full rises; nothing is lost.
// Reset: rst (synchronous) empties both queues, returns the registers to
// their defaults and restarts the stream at its first bar.
module parabolic_sar_tracker #(
  parameter int BAR_QUEUE_DEPTH    = 2,
  parameter int RESULT_QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  pst_pkg::bar_t        bar,
  output logic                 empty,
  input  logic                 pop,
  output pst_pkg::result_t     result,
  input  logic                 cfg_wr,
  input  pst_pkg::reg_index_t  cfg_index,
  input  pst_pkg::accel_t      cfg_data
);
  import pst_pkg::*;

  cfg_t        cfg;
  logic        q_push;
  logic        q_full;
  tagged_bar_t q_in;
  logic        q_empty;
  logic        q_pop;
  tagged_bar_t q_out;
  logic        r_push;
  logic        r_full;
  result_t     r_in;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.af_step <= AF_STEP_RESET;
      cfg.af_max  <= AF_MAX_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_AF_STEP: cfg.af_step <= cfg_data;
        REG_AF_MAX:  cfg.af_max  <= cfg_data;
        default:     cfg.af_step <= cfg.af_step;
      endcase
    end
  end

  pst_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .bar    (bar),
    .q_push (q_push),
    .q_full (q_full),
    .q_word (q_in)
  );

  pst_fifo #(
    .WIDTH ($bits(tagged_bar_t)),
    .DEPTH (BAR_QUEUE_DEPTH)
  ) u_bar_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_in),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_out)
  );

  pst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_word  (q_out),
    .r_push  (r_push),
    .r_full  (r_full),
    .r_word  (r_in)
  );

  pst_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .full  (r_full),
    .wdata (r_in),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

endmodule

FILE: verif/pst_check.sv
// Result checker for the parabolic stop-and-reverse tracker testbench.
// Watches the bar, result and register channels, predicts each stop word.
// Depends on pst_pkg.
`timescale 1ns / 100ps

module pst_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  pst_pkg::bar_t       bar,
  input  logic                empty,
  input  logic                pop,
  input  pst_pkg::result_t    result,
  input  logic                cfg_wr,
  input  pst_pkg::reg_index_t cfg_index,
  input  pst_pkg::accel_t     cfg_data,
  output int                  errors,
  output int                  outstanding,
  output int                  words_checked,
  output int                  flips_seen
);
  import pst_pkg::*;

  localparam int MAX_REPORTS = 20;

  // Register copies
  accel_t step_cfg;
  accel_t max_cfg;

  // Tracker state
  bar_phase_t phase;
  price_t     pending_level;
  price_t     ext_pt;
  accel_t     af_cur;
  logic       is_long;
  price_t     hi_since_flip;
  price_t     lo_since_flip;
  price_t     last_high;
  price_t     last_low;

  result_t    stop_words_q[$];
  result_t    want;

  // Move the level toward the extreme point by af, flooring the scaled step
  function automatic price_t project_level(input price_t lvl, input price_t ep,
                                           input accel_t af);
    longint     diff;
    longint     delta;
    longint     res;
    logic [63:0] mag;
    logic [63:0] prod;
    diff = longint'({32'd0, ep}) - longint'({32'd0, lvl});
    mag  = (diff < 0) ? -diff : diff;
    prod = mag * {48'd0, af};
    if (diff >= 0) begin
      delta = longint'(prod >> FRAC_W);
    end else begin
      delta = -longint'((prod + 64'd65535) >> FRAC_W);
    end
    res = longint'({32'd0, lvl}) + delta;
    if (res < 0) begin
      return '0;
    end else if (res > longint'(64'hFFFF_FFFF)) begin
      return '1;
    end
    return res[PRICE_W-1:0];
  endfunction

  // Advance the tracker by one bar and return the stop word it should give
  function automatic result_t track_bar(input bar_t b);
    price_t            h;
    price_t            l;
    price_t            lvl;
    price_t            nxt;
    logic              flip;
    logic [ACCEL_W:0]  af_sum;
    result_t           r;
    h    = b.high_price;
    l    = b.low_price;
    flip = 1'b0;
    if (phase == PH_FIRST) begin
      // first bar only seeds the extremes
      hi_since_flip = h;
      lo_since_flip = l;
      is_long       = 1'b0;
      phase         = PH_SECOND;
      lvl           = h;
      nxt           = h;
    end else begin
      if (h > hi_since_flip) hi_since_flip = h;
      if (l < lo_since_flip) lo_since_flip = l;
      if (phase == PH_SECOND) begin
        lvl     = hi_since_flip;
        ext_pt  = l;
        af_cur  = step_cfg;
        is_long = 1'b0;
        phase   = PH_RUN;
      end else begin
        lvl = pending_level;
        // stop hit: flip trend, restart from the extreme since the last flip
        if (is_long && lvl > l) begin
          is_long = 1'b0;
          lvl     = hi_since_flip;
          ext_pt  = l;
          af_cur  = step_cfg;
          flip    = 1'b1;
        end else if (!is_long && lvl < h) begin
          is_long = 1'b1;
          lvl     = lo_since_flip;
          ext_pt  = h;
          af_cur  = step_cfg;
          flip    = 1'b1;
        end
        if (flip) begin
          hi_since_flip = h;
          lo_since_flip = l;
        end else if (is_long ? (h > ext_pt) : (l < ext_pt)) begin
          // new extreme point: raise acceleration, capped
          af_sum = {1'b0, af_cur} + {1'b0, step_cfg};
          ext_pt = is_long ? h : l;
          af_cur = (af_sum > {1'b0, max_cfg}) ? max_cfg : af_sum[ACCEL_W-1:0];
        end
      end
      nxt = project_level(lvl, ext_pt, af_cur);
      // clamp against this bar and the previous one
      if (is_long) begin
        if (nxt > l || nxt > last_low) nxt = (l < last_low) ? l : last_low;
      end else begin
        if (nxt < h || nxt < last_high) nxt = (h > last_high) ? h : last_high;
      end
      pending_level = nxt;
    end
    last_high    = h;
    last_low     = l;
    r.sar_level  = lvl;
    r.sar_next   = nxt;
    r.trend_long = is_long;
    r.reversal   = flip;
    return r;
  endfunction

  // Predict on each accepted bar word, compare on each accepted result word
  always @(posedge clk) begin
    if (rst) begin
      step_cfg      = AF_STEP_RESET;
      max_cfg       = AF_MAX_RESET;
      phase         = PH_FIRST;
      pending_level = '0;
      ext_pt        = '0;
      af_cur        = AF_STEP_RESET;
      is_long       = 1'b0;
      hi_since_flip = '0;
      lo_since_flip = '1;
      last_high     = '0;
      last_low      = '0;
      stop_words_q.delete();
      errors        = 0;
      words_checked = 0;
      flips_seen    = 0;
    end else begin
      if (pop && !empty) begin
        if (stop_words_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected stop word level %0d next %0d long %0b flip %0b",
                     $time, result.sar_level, result.sar_next, result.trend_long,
                     result.reversal);
          end
        end else begin
          want = stop_words_q.pop_front();
          words_checked++;
          if (result.sar_level !== want.sar_level || result.sar_next !== want.sar_next ||
              result.trend_long !== want.trend_long ||
              result.reversal !== want.reversal) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: stop word %0d expected level %0d next %0d long %0b flip %0b",
                       $time, words_checked, want.sar_level, want.sar_next,
                       want.trend_long, want.reversal);
              $display("%0t: stop word %0d actual   level %0d next %0d long %0b flip %0b",
                       $time, words_checked, result.sar_level, result.sar_next,
                       result.trend_long, result.reversal);
            end
          end
        end
      end
      if (push && !full) begin
        want = track_bar(bar);
        stop_words_q.push_back(want);
        if (want.reversal) flips_seen++;
      end
      // register writes apply from the next bar on
      if (cfg_wr) begin
        case (cfg_index)
          REG_AF_STEP: step_cfg = cfg_data;
          REG_AF_MAX:  max_cfg  = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = stop_words_q.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the parabolic stop-and-reverse tracker.
// Drives bar words and register writes, stalls the result side, gives the verdict.
// Depends on pst_pkg, parabolic_sar_tracker and pst_check.
`timescale 1ns / 100ps

module tb;
  import pst_pkg::*;

  localparam int CYCLE_LIMIT    = 400_000;
  localparam int PHASES         = 7;
  localparam int BARS_PER_PHASE = 207;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  logic       full;
  bar_t       bar_in    = '0;
  logic       empty;
  logic       pop       = 1'b0;
  result_t    result;
  logic       cfg_wr    = 1'b0;
  reg_index_t cfg_index = REG_AF_STEP;
  accel_t     cfg_data  = '0;

  int fail_count;
  int outstanding;
  int words_checked;
  int flips_seen;
  int cycle_count = 0;
  int bars_sent   = 0;
  int reg_writes  = 0;
  int burst_left  = 0;

  // Price walk state
  longint walk_price = 1_000_000;
  int     walk_dir   = 1;
  int     walk_scale = 256;

  // Receiver stall pattern
  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_tick    = 0;

  // Register settings per random phase; the last one is drawn at run time
  accel_t step_plan [PHASES] = '{16'd1311, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd40000,
                                 16'd0};
  accel_t max_plan  [PHASES] = '{16'd13107, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd20000,
                                 16'd0};

  // Trend down, turn up, run up, inverted bar, turn down, then field extremes
  bar_t opening_bars [16] = '{
    {32'd1000, 32'd900},  {32'd1010, 32'd950},  {32'd990, 32'd880},
    {32'd970, 32'd860},   {32'd960, 32'd850},   {32'd2000, 32'd1500},
    {32'd2100, 32'd1900}, {32'd2200, 32'd2000}, {32'd2300, 32'd2150},
    {32'd1800, 32'd2300}, {32'd1000, 32'd500},  {32'hFFFF_FFFF, 32'd0},
    {32'd0, 32'd0},       {32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {32'd0, 32'hFFFF_FFFF}, {32'hFFFF_FFFE, 32'd1}
  };

  parabolic_sar_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .bar       (bar_in),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pst_check i_check (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .bar           (bar_in),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .cfg_wr        (cfg_wr),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (fail_count),
    .outstanding   (outstanding),
    .words_checked (words_checked),
    .flips_seen    (flips_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Stall the result side on a rotating pattern, redrawn when stall_tick wraps to zero
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (stall_tick == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'hFFFF;
          1:       stall_pattern = 16'h0001 << $urandom_range(0, 15);
          default: stall_pattern = 16'($urandom) | 16'h0001;
        endcase
      end
      stall_tick    = (stall_tick + 1) % 64;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      pop <= stall_pattern[0];
    end
  end

  function automatic price_t clamp_price(input longint v);
    if (v < 0) return '0;
    if (v > longint'(64'hFFFF_FFFF)) return '1;
    return v[31:0];
  endfunction

  // Draw the next bar: mostly a trending walk, some noise and inverted bars
  function automatic bar_t market_bar();
    int     pick;
    longint span;
    bar_t   b;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      b = {$urandom, $urandom};
    end else begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0:       walk_price = $urandom_range(0, 2000);
          1:       walk_price = longint'(64'hFFFF_FFFF) - $urandom_range(0, 2000);
          default: walk_price = longint'({32'd0, $urandom});
        endcase
      end
      if ($urandom_range(0, 29) == 0) walk_scale = 1 << $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0) walk_dir = -walk_dir;
      span       = $urandom_range(0, walk_scale);
      walk_price = clamp_price(walk_price + walk_dir * span);
      b.high_price = clamp_price(walk_price + $urandom_range(0, walk_scale));
      b.low_price  = clamp_price(walk_price - $urandom_range(0, walk_scale));
      if (pick < 13) b = {b.low_price, b.high_price};
    end
    return b;
  endfunction

  // Offer one bar word; return at the falling edge after it was taken
  task automatic send_bar(input bar_t b);
    bar_in <= b;
    push   <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    bars_sent++;
    @(negedge clk);
  endtask

  // Drop push for a gap, with junk on the bar lines
  task automatic hold_off(input int cycles);
    push   <= 1'b0;
    bar_in <= {$urandom, $urandom};
    repeat (cycles) @(negedge clk);
  endtask

  // Stop sending and wait until every stop word is back
  task automatic drain();
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write both registers, the step then the ceiling, in consecutive cycles
  task automatic write_regs(input accel_t step_val, input accel_t max_val);
    cfg_wr    <= 1'b1;
    cfg_index <= REG_AF_STEP;
    cfg_data  <= step_val;
    @(negedge clk);
    cfg_index <= REG_AF_MAX;
    cfg_data  <= max_val;
    @(negedge clk);
    cfg_wr    <= 1'b0;
    reg_writes += 2;
  endtask

  initial begin
    int p;
    int k;
    int gap;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed bars at the reset settings
    for (k = 0; k < 16; k++) send_bar(opening_bars[k]);

    // Fast acceleration that hits its ceiling, down then up
    drain();
    write_regs(16'd30000, 16'd40000);
    for (k = 0; k < 5; k++) send_bar({price_t'(5000 - 300 * k), price_t'(4900 - 300 * k)});
    for (k = 0; k < 5; k++) send_bar({price_t'(4000 + 600 * k), price_t'(3900 + 600 * k)});

    // Random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      drain();
      if (p == PHASES - 1) begin
        write_regs(accel_t'($urandom_range(0, 65535)), accel_t'($urandom_range(0, 65535)));
      end else begin
        write_regs(step_plan[p], max_plan[p]);
      end
      for (k = 0; k < BARS_PER_PHASE; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap != 0) hold_off(gap);
        end
        burst_left--;
        send_bar(market_bar());
      end
    end

    // Let the last stop words come out
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run covered %0d bars, %0d stop words checked, %0d trend flips",
             bars_sent, words_checked, flips_seen);
    $display("%0d register writes over %0d settings, %0d mismatches",
             reg_writes, PHASES + 1, fail_count);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
